// ===== rtl/core/ppu_pkg.sv =====
// shared types, codes and constants of the picture-unit register port
package ppu_pkg;

   localparam int NAMETABLE_BYTES  = 2048;
   localparam int SPRITE_MEM_BYTES = 256;
   localparam int PALETTE_ENTRIES  = 32;

   localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
   localparam int SPR_AW = $clog2(SPRITE_MEM_BYTES);
   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

   localparam int OP_W   = 2;
   localparam int REG_W  = 3;
   localparam int BYTE_W = 8;
   localparam int VA_W   = 16;
   localparam int DOT_W  = 9;

   typedef enum logic [OP_W-1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   localparam logic [REG_W-1:0] REG_CTRL     = 3'd0;
   localparam logic [REG_W-1:0] REG_MASK     = 3'd1;
   localparam logic [REG_W-1:0] REG_STATUS   = 3'd2;
   localparam logic [REG_W-1:0] REG_OAM_ADDR = 3'd3;
   localparam logic [REG_W-1:0] REG_OAM_DATA = 3'd4;
   localparam logic [REG_W-1:0] REG_SCROLL   = 3'd5;
   localparam logic [REG_W-1:0] REG_ADDR     = 3'd6;
   localparam logic [REG_W-1:0] REG_DATA     = 3'd7;

   localparam logic [VA_W-1:0] STEP_NARROW = 16'd1;
   localparam logic [VA_W-1:0] STEP_WIDE   = 16'd32;

   localparam logic [3:0] NT_PAGE  = 4'h2;
   localparam logic [7:0] PAL_PAGE = 8'h3F;

   localparam logic [DOT_W-1:0] DOT_LAST     = 9'd340;
   localparam logic [DOT_W-1:0] LINE_VBLANK  = 9'd241;
   localparam logic [DOT_W-1:0] LINE_LAST    = 9'd260;
   localparam logic [DOT_W-1:0] LINE_PRE     = 9'h1FF;

   typedef enum logic [1:0] {
      RES_FIXED  = 2'd0,
      RES_SPRITE = 2'd1,
      RES_DATA   = 2'd2
   } res_type;

   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_NT   = 2'd1,
      SRC_PAL  = 2'd2
   } src_type;

   typedef struct packed {
      res_type           kind;
      src_type           src;
      logic              high;
      logic [BYTE_W-1:0] rd;
      logic              nmi;
      logic              done;
   } stage_type;

endpackage

// ===== rtl/core/ppu_ifs.sv =====
// valid/ready channel interfaces for request, response and csr words
interface ppu_req_if;
   logic                          valid;
   logic                          ready;
   logic [ppu_pkg::OP_W-1:0]      operation;
   logic [ppu_pkg::REG_W-1:0]     register_index;
   logic [ppu_pkg::BYTE_W-1:0]    write_data;
   modport source (output valid, operation, register_index, write_data, input ready);
   modport sink   (input valid, operation, register_index, write_data, output ready);
endinterface

interface ppu_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ppu_pkg::BYTE_W-1:0]    read_data;
   logic                          nmi_request;
   logic                          frame_done;
   modport source (output valid, read_data, nmi_request, frame_done, input ready);
   modport sink   (input valid, read_data, nmi_request, frame_done, output ready);
endinterface

interface ppu_csr_if;
   logic valid;
   logic ready;
   logic mirroring_mode;
   modport source (output valid, mirroring_mode, input ready);
   modport sink   (input valid, mirroring_mode, output ready);
endinterface

// ===== rtl/core/ppu_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module ppu_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/ppu_front.sv =====
// request stage: register file, frame timer, address mapping, ram access and clearing pass
module ppu_front (
   input  logic                       clock,
   input  logic                       reset,
   ppu_req_if.sink                    req,
   ppu_csr_if.sink                    csr,
   input  logic                       back_ready,
   output logic                       push,
   output ppu_pkg::stage_type         stage,
   output logic                       nt_we,
   output logic [ppu_pkg::NT_AW-1:0]  nt_waddr,
   output logic [ppu_pkg::NT_AW-1:0]  nt_raddr,
   output logic                       spr_we,
   output logic [ppu_pkg::SPR_AW-1:0] spr_waddr,
   output logic [ppu_pkg::SPR_AW-1:0] spr_raddr,
   output logic                       pal_we,
   output logic [ppu_pkg::PAL_AW-1:0] pal_waddr,
   output logic [ppu_pkg::PAL_AW-1:0] pal_raddr,
   output logic [ppu_pkg::BYTE_W-1:0] wdata
);
   import ppu_pkg::*;

   logic [BYTE_W-1:0] ctrl_ff, ctrl_in;
   logic [1:0]        status_ff, status_in;
   logic [SPR_AW-1:0] oam_addr_ff, oam_addr_in;
   logic              toggle_ff, toggle_in;
   logic [BYTE_W-1:0] last_ff, last_in;
   logic [VA_W-1:0]   vaddr_ff, vaddr_in;
   logic [DOT_W-1:0]  dot_ff, dot_in;
   logic [DOT_W-1:0]  scan_ff, scan_in;
   logic              mirror_ff;
   logic              clear_ff;
   logic [NT_AW-1:0]  clr_cnt_ff;

   logic [DOT_W-1:0]  dot_a, dot_b, scan_b;
   logic              wrap_frame;
   logic [VA_W-1:0]   vaddr_step;
   logic              in_nt, in_pal, is_high;
   logic [NT_AW-1:0]  nt_idx;
   logic [PAL_AW-1:0] pal_ridx, pal_widx;
   logic [REG_W-1:0]  reg_idx;

   assign req.ready = !clear_ff && back_ready;
   assign csr.ready = 1'b1;
   assign push      = req.valid && req.ready;
   assign reg_idx   = req.register_index;

   // video address decode
   assign in_nt   = (vaddr_ff[15:12] == NT_PAGE);
   assign in_pal  = (vaddr_ff[15:8] == PAL_PAGE);
   assign is_high = (vaddr_ff[15:8] >= PAL_PAGE);
   // horizontal pairs quadrants by bit 11, vertical by bit 10
   assign nt_idx  = {(mirror_ff ? vaddr_ff[10] : vaddr_ff[11]), vaddr_ff[9:0]};
   assign pal_ridx = (vaddr_ff[1:0] == 2'b00) ? '0 : vaddr_ff[PAL_AW-1:0];
   // backdrop writes outside 3f00-3f0f land with bit 4 of the entry flipped
   assign pal_widx = {vaddr_ff[4] ^ ((vaddr_ff[1:0] == 2'b00) && (vaddr_ff[7:4] != 4'h0)),
                      vaddr_ff[3:0]};
   assign vaddr_step = vaddr_ff + (ctrl_ff[2] ? STEP_WIDE : STEP_NARROW);

   // dot/scanline advance for one tick
   always_comb begin
      dot_a = (scan_ff == '0 && dot_ff == '0) ? 9'd1 : dot_ff;
      wrap_frame = 1'b0;
      if (dot_a > DOT_LAST) begin
         dot_b  = '0;
         scan_b = scan_ff + 9'd1;
         if (scan_ff == LINE_LAST) begin
            scan_b     = LINE_PRE;
            wrap_frame = 1'b1;
         end
      end else begin
         dot_b  = dot_a;
         scan_b = scan_ff;
      end
   end

   always_comb begin
      ctrl_in     = ctrl_ff;
      status_in   = status_ff;
      oam_addr_in = oam_addr_ff;
      toggle_in   = toggle_ff;
      last_in     = last_ff;
      vaddr_in    = vaddr_ff;
      dot_in      = dot_ff;
      scan_in     = scan_ff;
      stage       = '{kind: RES_FIXED, src: SRC_NONE, high: is_high, rd: '0,
                      nmi: 1'b0, done: 1'b0};
      nt_we       = 1'b0;
      spr_we      = 1'b0;
      pal_we      = 1'b0;
      if (push) begin
         case (op_type'(req.operation))
            OP_TICK: begin
               if (scan_ff == LINE_PRE && dot_ff == 9'd1) begin
                  status_in = '0;
               end
               if (scan_b == LINE_VBLANK && dot_b == 9'd1) begin
                  status_in[1] = 1'b1;
                  stage.nmi    = ctrl_ff[7];
               end
               stage.done = wrap_frame;
               dot_in     = dot_b + 9'd1;
               scan_in    = scan_b;
            end
            OP_READ: begin
               unique case (reg_idx)
                  REG_STATUS: begin
                     stage.rd     = {status_ff, 6'b0};
                     status_in[1] = 1'b0;
                     toggle_in    = 1'b0;
                  end
                  REG_OAM_DATA: begin
                     stage.kind = RES_SPRITE;
                  end
                  REG_DATA: begin
                     stage.kind = RES_DATA;
                     stage.src  = in_nt ? SRC_NT : (in_pal ? SRC_PAL : SRC_NONE);
                     vaddr_in   = vaddr_step;
                  end
                  default: begin
                  end
               endcase
            end
            OP_WRITE: begin
               unique case (reg_idx)
                  REG_CTRL:     ctrl_in = req.write_data;
                  REG_OAM_ADDR: oam_addr_in = req.write_data;
                  REG_OAM_DATA: begin
                     spr_we      = 1'b1;
                     oam_addr_in = oam_addr_ff + 8'd1;
                  end
                  REG_SCROLL:   toggle_in = ~toggle_ff;
                  REG_ADDR: begin
                     if (toggle_ff) begin
                        vaddr_in = {last_ff, req.write_data};
                        ctrl_in  = {ctrl_ff[7:2], 2'b00};
                     end
                     toggle_in = ~toggle_ff;
                     last_in   = req.write_data;
                  end
                  REG_DATA: begin
                     nt_we    = in_nt;
                     pal_we   = in_pal;
                     vaddr_in = vaddr_step;
                  end
                  // mask and status writes have no effect without rendering
                  REG_MASK, REG_STATUS: begin
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
      if (clear_ff) begin
         nt_we  = 1'b1;
         spr_we = 1'b1;
         pal_we = 1'b1;
      end
   end

   assign wdata     = clear_ff ? '0 : req.write_data;
   assign nt_waddr  = clear_ff ? clr_cnt_ff : nt_idx;
   assign spr_waddr = clear_ff ? clr_cnt_ff[SPR_AW-1:0] : oam_addr_ff;
   assign pal_waddr = clear_ff ? clr_cnt_ff[PAL_AW-1:0] : pal_widx;
   assign nt_raddr  = nt_idx;
   assign spr_raddr = oam_addr_ff;
   assign pal_raddr = pal_ridx;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff     <= '0;
         status_ff   <= '0;
         oam_addr_ff <= '0;
         toggle_ff   <= 1'b0;
         last_ff     <= '0;
         vaddr_ff    <= '0;
         dot_ff      <= '0;
         scan_ff     <= '0;
         mirror_ff   <= 1'b0;
         clear_ff    <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         ctrl_ff     <= ctrl_in;
         status_ff   <= status_in;
         oam_addr_ff <= oam_addr_in;
         toggle_ff   <= toggle_in;
         last_ff     <= last_in;
         vaddr_ff    <= vaddr_in;
         dot_ff      <= dot_in;
         scan_ff     <= scan_in;
         if (csr.valid) begin
            mirror_ff <= csr.mirroring_mode;
         end
         if (clear_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               clear_ff <= 1'b0;
            end
         end
      end
   end

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (scan_ff <= LINE_LAST) || (scan_ff == LINE_PRE))
      else $error("scanline out of range");

   a_dot_range: assert property (@(posedge clock) disable iff (reset)
      dot_ff <= (DOT_LAST + 9'd1))
      else $error("dot count out of range");

   a_nmi_vblank: assert property (@(posedge clock) disable iff (reset)
      (push && stage.nmi) |=> status_ff[1])
      else $error("nmi without vblank");
endmodule

// ===== rtl/core/ppu_back.sv =====
// response stage: ram data select, read buffer and output register
module ppu_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ppu_pkg::stage_type         stage,
   input  logic [ppu_pkg::BYTE_W-1:0] nt_rdata,
   input  logic [ppu_pkg::BYTE_W-1:0] spr_rdata,
   input  logic [ppu_pkg::BYTE_W-1:0] pal_rdata,
   output logic                       back_ready,
   ppu_rsp_if.source                  rsp
);
   import ppu_pkg::*;

   logic              b_valid_ff, b_valid_in;
   stage_type         b_stage_ff;
   logic              c_valid_ff, c_valid_in;
   logic [BYTE_W-1:0] c_rd_ff;
   logic              c_nmi_ff, c_done_ff;
   logic [BYTE_W-1:0] buf_ff, buf_in;
   logic              adv_b;
   logic [BYTE_W-1:0] vid_new, rd_b;

   assign adv_b      = b_valid_ff && (!c_valid_ff || rsp.ready);
   assign back_ready = !b_valid_ff || adv_b;
   assign b_valid_in = push || (b_valid_ff && !adv_b);
   assign c_valid_in = adv_b || (c_valid_ff && !rsp.ready);

   always_comb begin
      case (b_stage_ff.src)
         SRC_NT:  vid_new = nt_rdata;
         SRC_PAL: vid_new = pal_rdata;
         default: vid_new = '0;
      endcase
      case (b_stage_ff.kind)
         RES_SPRITE: rd_b = spr_rdata;
         RES_DATA:   rd_b = b_stage_ff.high ? vid_new : buf_ff;
         default:    rd_b = b_stage_ff.rd;
      endcase
      buf_in = (adv_b && b_stage_ff.kind == RES_DATA) ? vid_new : buf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         buf_ff     <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         buf_ff     <= buf_in;
      end
      if (push) begin
         b_stage_ff <= stage;
      end
      if (adv_b) begin
         c_rd_ff   <= rd_b;
         c_nmi_ff  <= b_stage_ff.nmi;
         c_done_ff <= b_stage_ff.done;
      end
   end

   assign rsp.valid       = c_valid_ff;
   assign rsp.read_data   = c_rd_ff;
   assign rsp.nmi_request = c_nmi_ff;
   assign rsp.frame_done  = c_done_ff;

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push |-> (!b_valid_ff || adv_b))
      else $error("stage overwritten while busy");

   a_tick_no_byte: assert property (@(posedge clock) disable iff (reset)
      (c_valid_ff && (c_nmi_ff || c_done_ff)) |-> (c_rd_ff == '0))
      else $error("tick word carries read data");

   a_nmi_not_wrap: assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> !(c_nmi_ff && c_done_ff))
      else $error("nmi and frame wrap on one tick");
endmodule

// ===== rtl/core/ppu_register_port_and_frame_timing.sv =====
// top level of the picture-unit register port and frame timer
// The block takes one request word per clock while it is ready (tick, register read or
// register write) and returns exactly one response word for each, in order, through a
// holding stage and then an output register; the holding stage and output register let
// a new word enter while a response waits. The rate is set by the single read and write
// port of each ram: all ram traffic of a word happens at its acceptance edge and read
// data comes back from the registered ram output. After reset a clearing pass steps
// through all 2048 nametable addresses and zeroes the nametable, sprite and palette
// rams; no request word is taken during it, csr writes are taken at any time.
module ppu_register_port_and_frame_timing (
   input  logic      clock,
   input  logic      reset,
   ppu_req_if.sink   req_if,
   ppu_rsp_if.source rsp_if,
   ppu_csr_if.sink   csr_if
);
   import ppu_pkg::*;

   // handshake between the request stage and the response stage
   logic              back_ready;
   logic              push;
   stage_type         stage;

   // ram ports, driven by the request stage or the clearing pass
   logic              nt_we, spr_we, pal_we;
   logic [NT_AW-1:0]  nt_waddr, nt_raddr;
   logic [SPR_AW-1:0] spr_waddr, spr_raddr;
   logic [PAL_AW-1:0] pal_waddr, pal_raddr;
   logic [BYTE_W-1:0] wdata;
   logic [BYTE_W-1:0] nt_rdata, spr_rdata, pal_rdata;

   // register file, timer, address decode and clearing pass
   ppu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .csr        (csr_if),
      .back_ready (back_ready),
      .push       (push),
      .stage      (stage),
      .nt_we      (nt_we),
      .nt_waddr   (nt_waddr),
      .nt_raddr   (nt_raddr),
      .spr_we     (spr_we),
      .spr_waddr  (spr_waddr),
      .spr_raddr  (spr_raddr),
      .pal_we     (pal_we),
      .pal_waddr  (pal_waddr),
      .pal_raddr  (pal_raddr),
      .wdata      (wdata)
   );

   // nametable ram, 2 KiB behind the mirror
   ppu_ram #(.DEPTH(NAMETABLE_BYTES), .WIDTH(BYTE_W)) u_nt_ram (
      .clock   (clock),
      .wr_en   (nt_we),
      .wr_addr (nt_waddr),
      .wr_data (wdata),
      .rd_en   (push),
      .rd_addr (nt_raddr),
      .rd_data (nt_rdata)
   );

   // sprite attribute ram
   ppu_ram #(.DEPTH(SPRITE_MEM_BYTES), .WIDTH(BYTE_W)) u_spr_ram (
      .clock   (clock),
      .wr_en   (spr_we),
      .wr_addr (spr_waddr),
      .wr_data (wdata),
      .rd_en   (push),
      .rd_addr (spr_raddr),
      .rd_data (spr_rdata)
   );

   // palette ram, mirrored entries folded in the address decode
   ppu_ram #(.DEPTH(PALETTE_ENTRIES), .WIDTH(BYTE_W)) u_pal_ram (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (pal_waddr),
      .wr_data (wdata),
      .rd_en   (push),
      .rd_addr (pal_raddr),
      .rd_data (pal_rdata)
   );

   // read buffer and response register
   ppu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .stage      (stage),
      .nt_rdata   (nt_rdata),
      .spr_rdata  (spr_rdata),
      .pal_rdata  (pal_rdata),
      .back_ready (back_ready),
      .rsp        (rsp_if)
   );
endmodule
